// ===== design/sqn_freshness_check_assert.svh =====
// ----------------------------------------------------------------------------
// sqn_freshness_check_assert
// assertion macros shared by the sequence number freshness check
// ----------------------------------------------------------------------------
`ifndef SQN_FRESHNESS_CHECK_ASSERT_SVH
`define SQN_FRESHNESS_CHECK_ASSERT_SVH

// checked outside reset
`define SQN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define SQN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== design/sqn_pkg.sv =====
// ----------------------------------------------------------------------------
// sqn_pkg
// types, codes and microprogram of the sequence number freshness check
// ----------------------------------------------------------------------------
`default_nettype none

package sqn_pkg;

    localparam int SQN_W     = 48;
    localparam int STATUS_W  = 2;
    localparam int DEXP_W    = 6;
    localparam int AGE_W     = 43;
    localparam int CFG_IDX_W = 1;
    localparam int PC_W      = 3;

    localparam logic [DEXP_W-1:0] DEXP_RST = 6'd28;
    localparam logic [AGE_W-1:0]  AGE_RST  = 43'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELTA_EXP = 1'b0,
        CFG_AGE_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 2'd0,
        ST_AHEAD  = 2'd1,
        ST_OLD    = 2'd2,
        ST_REPLAY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_MRED   = 3'd1,
        OP_RRED   = 3'd2,
        OP_WMSQ   = 3'd3,
        OP_SCAN   = 3'd4,
        OP_RDST   = 3'd5,
        OP_DIFF   = 3'd6,
        OP_DECIDE = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_NO_IN     = 3'd1,
        C_M_BIG     = 3'd2,
        C_R_BIG     = 3'd3,
        C_SCAN_BUSY = 3'd4,
        C_OUT_BUSY  = 3'd5
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic no_in;
        logic m_big;
        logic r_big;
        logic scan_busy;
        logic out_busy;
    } t_flags;

    // microprogram: jump to target while cond holds, else next step
    // the last step falls through to step 0
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        unique case (pc)
            3'd0: uw = '{op: OP_LOAD,   cond: C_NO_IN,     target: 3'd0};
            3'd1: uw = '{op: OP_MRED,   cond: C_M_BIG,     target: 3'd1};
            3'd2: uw = '{op: OP_RRED,   cond: C_R_BIG,     target: 3'd2};
            3'd3: uw = '{op: OP_WMSQ,   cond: C_NEVER,     target: 3'd0};
            3'd4: uw = '{op: OP_SCAN,   cond: C_SCAN_BUSY, target: 3'd4};
            3'd5: uw = '{op: OP_RDST,   cond: C_NEVER,     target: 3'd0};
            3'd6: uw = '{op: OP_DIFF,   cond: C_NEVER,     target: 3'd0};
            3'd7: uw = '{op: OP_DECIDE, cond: C_OUT_BUSY,  target: 3'd7};
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

// ===== design/sqn_in_if.sv =====
// ----------------------------------------------------------------------------
// sqn_in_if
// request channel: received and highest known sequence numbers
// ----------------------------------------------------------------------------
`default_nettype none

interface sqn_in_if;
    import sqn_pkg::*;

    logic             valid;
    logic             ready;
    logic [SQN_W-1:0] sqn_received;
    logic [SQN_W-1:0] max_sqn;
    logic             max_sqn_valid;

    modport source (
        output valid, sqn_received, max_sqn, max_sqn_valid,
        input  ready
    );

    modport sink (
        input  valid, sqn_received, max_sqn, max_sqn_valid,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/sqn_out_if.sv =====
// ----------------------------------------------------------------------------
// sqn_out_if
// result channel: check status and highest stored sequence number
// ----------------------------------------------------------------------------
`default_nettype none

interface sqn_out_if;
    import sqn_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SQN_W-1:0]    highest_sqn;

    modport source (
        output valid, status, highest_sqn,
        input  ready
    );

    modport sink (
        input  valid, status, highest_sqn,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/sqn_freshness_check.sv =====
// ----------------------------------------------------------------------------
// sqn_freshness_check
// sequence number freshness check against a table of stored numbers
// ----------------------------------------------------------------------------
// i_in carries one request beat: received number, highest known number and
// its valid flag. o_res returns one beat per request: status and the stored
// number with the largest counter. i_cfg_* writes delta exponent (index 0)
// and age limit (index 1); write them only while no request is in flight,
// the block itself does not enforce this. Each index field is reduced by
// repeated TABLE_ENTRIES subtraction, one step per subtraction, while it
// reaches TABLE_ENTRIES or more. The result beat becomes valid in the cycle
// in which the next request can be taken. The table scan dominates: one
// entry per cycle through the single, registered table read port, stepped
// by the microcode sequencer.
// Reset clears the table valid bits (every entry reads as zero), restores the
// register defaults and returns the sequencer to the accept step.
// A stalled result holds in the output register; the block takes the next
// request meanwhile and waits in its last step only if a new result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module sqn_freshness_check #(
    parameter int IND_BITS      = 5,
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sqn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sqn_pkg::AGE_W-1:0]       i_cfg_data,
    sqn_in_if.sink                               i_in,
    sqn_out_if.source                            o_res
);
    import sqn_pkg::*;

    t_uword uw;
    t_flags flags;

    sqn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uw    (uw)
    );

    sqn_dp #(
        .IND_BITS      (IND_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_uw       (uw),
        .o_flags    (flags),
        .i_in       (i_in),
        .o_res      (o_res)
    );
endmodule

`default_nettype wire

// ===== design/sqn_seq.sv =====
// ----------------------------------------------------------------------------
// sqn_seq
// step counter and microcode table, conditional jumps on datapath flags
// ----------------------------------------------------------------------------
`default_nettype none

module sqn_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sqn_pkg::t_flags i_flags,
    output sqn_pkg::t_uword      o_uw
);
    import sqn_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;
    logic            take;

    assign uw   = ucode(r_pc);
    assign o_uw = uw;

    always_comb begin
        case (uw.cond)
            C_NO_IN:     take = i_flags.no_in;
            C_M_BIG:     take = i_flags.m_big;
            C_R_BIG:     take = i_flags.r_big;
            C_SCAN_BUSY: take = i_flags.scan_busy;
            C_OUT_BUSY:  take = i_flags.out_busy;
            default:     take = 1'b0;
        endcase
        n_pc = take ? uw.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end
endmodule

`default_nettype wire

// ===== design/sqn_dp.sv =====
// ----------------------------------------------------------------------------
// sqn_dp
// datapath: sequence number table, maximum scan, window checks, result beat
// ----------------------------------------------------------------------------
`default_nettype none
`include "sqn_freshness_check_assert.svh"

module sqn_dp #(
    parameter int IND_BITS      = 5,
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sqn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sqn_pkg::AGE_W-1:0]       i_cfg_data,
    input  wire sqn_pkg::t_uword                 i_uw,
    output sqn_pkg::t_flags                      o_flags,
    sqn_in_if.sink                               i_in,
    sqn_out_if.source                            o_res
);
    import sqn_pkg::*;

    localparam int CNT_W   = SQN_W - IND_BITS;
    localparam int DIFF_W  = CNT_W + 1;
    localparam int LCMP_W  = (DIFF_W > AGE_W ? DIFF_W : AGE_W) + 1;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int RED_W   = (IND_BITS > IDX_W ? IND_BITS : IDX_W) + 1;
    localparam int SCNT_W  = $clog2(TABLE_ENTRIES + 1);

    // configuration
    logic [DEXP_W-1:0] r_delta_exp;
    logic [AGE_W-1:0]  r_age_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_exp <= DEXP_RST;
            r_age_limit <= AGE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DELTA_EXP: r_delta_exp <= i_cfg_data[DEXP_W-1:0];
                CFG_AGE_LIMIT: r_age_limit <= i_cfg_data;
            endcase
        end
    end

    // beat capture and index reduction
    logic [SQN_W-1:0] r_rcv;
    logic [SQN_W-1:0] r_msq;
    logic             r_msq_vld;
    logic [RED_W-1:0] r_midx;
    logic [RED_W-1:0] r_ridx;
    logic             m_big;
    logic             r_big;
    logic             load;

    assign load       = (i_uw.op == OP_LOAD) && i_in.valid;
    assign i_in.ready = (i_uw.op == OP_LOAD);
    assign m_big      = r_midx >= RED_W'(TABLE_ENTRIES);
    assign r_big      = r_ridx >= RED_W'(TABLE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rcv     <= i_in.sqn_received;
            r_msq     <= i_in.max_sqn;
            r_msq_vld <= i_in.max_sqn_valid;
            r_midx    <= RED_W'(i_in.max_sqn[IND_BITS-1:0]);
            r_ridx    <= RED_W'(i_in.sqn_received[IND_BITS-1:0]);
        end else begin
            if (i_uw.op == OP_MRED && m_big) begin
                r_midx <= r_midx - RED_W'(TABLE_ENTRIES);
            end
            if (i_uw.op == OP_RRED && r_big) begin
                r_ridx <= r_ridx - RED_W'(TABLE_ENTRIES);
            end
        end
    end

    // table with per-entry valid bits, unwritten entries read as zero
    logic [SQN_W-1:0]         r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;
    logic [SQN_W-1:0]         r_rdata;
    logic                     r_rvld;
    logic [SQN_W-1:0]         ent;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         wr_addr;
    logic [SQN_W-1:0]         wr_data;
    logic                     wr_en;
    logic                     wr_msq;
    logic                     decide_go;
    logic                     accept;
    logic                     out_busy;

    logic [SCNT_W-1:0]  r_scan_cnt;
    logic               r_scan_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic               scan_issue;

    assign scan_issue = r_scan_cnt < SCNT_W'(TABLE_ENTRIES);
    assign rd_addr    = (i_uw.op == OP_SCAN) ? r_scan_cnt[IDX_W-1:0]
                                             : r_ridx[IDX_W-1:0];
    assign ent        = r_rvld ? r_rdata : '0;

    assign out_busy  = o_res.valid && !o_res.ready;
    assign decide_go = (i_uw.op == OP_DECIDE) && !out_busy;
    assign wr_msq    = (i_uw.op == OP_WMSQ) && r_msq_vld;
    assign wr_en     = wr_msq || (decide_go && accept);
    assign wr_addr   = wr_msq ? r_midx[IDX_W-1:0] : r_ridx[IDX_W-1:0];
    assign wr_data   = wr_msq ? r_msq : r_rcv;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_rvld <= r_vld[rd_addr];
        end
    end

    // maximum counter scan, pipelined over the read latency
    logic [CNT_W-1:0] r_best_cnt;
    logic [SQN_W-1:0] r_best_sqn;
    logic [IDX_W-1:0] r_best_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt  <= '0;
            r_scan_pend <= 1'b0;
        end else if (i_uw.op == OP_WMSQ) begin
            r_scan_cnt  <= '0;
            r_scan_pend <= 1'b0;
        end else if (i_uw.op == OP_SCAN) begin
            r_scan_pend <= scan_issue;
            if (scan_issue) begin
                r_scan_cnt <= r_scan_cnt + SCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uw.op == OP_SCAN) begin
            r_pend_idx <= r_scan_cnt[IDX_W-1:0];
            if (r_scan_pend && (r_pend_idx == '0 ||
                    ent[SQN_W-1:IND_BITS] > r_best_cnt)) begin
                r_best_cnt  <= ent[SQN_W-1:IND_BITS];
                r_best_sqn  <= ent;
                r_best_slot <= r_pend_idx;
            end
        end
    end

    // differences and compares
    logic [CNT_W-1:0]         rcv_cnt;
    logic signed [DIFF_W-1:0] r_ahead;
    logic signed [DIFF_W-1:0] r_lag;
    logic                     r_not_newer;
    logic                     r_rcv_top;
    logic signed [DIFF_W-1:0] thr;
    logic signed [LCMP_W-1:0] lag_x;
    logic signed [LCMP_W-1:0] age_x;
    logic                     too_ahead;
    logic                     too_old;
    t_status                  status;

    assign rcv_cnt = r_rcv[SQN_W-1:IND_BITS];

    always_ff @(posedge i_clk) begin
        if (i_uw.op == OP_DIFF) begin
            r_ahead     <= $signed({1'b0, rcv_cnt}) - $signed({1'b0, r_best_cnt});
            r_lag       <= $signed({1'b0, r_best_cnt}) - $signed({1'b0, rcv_cnt});
            r_not_newer <= rcv_cnt <= ent[SQN_W-1:IND_BITS];
            r_rcv_top   <= (rcv_cnt > r_best_cnt) ||
                           (rcv_cnt == r_best_cnt && r_ridx[IDX_W-1:0] <= r_best_slot);
        end
    end

    assign thr       = {{(DIFF_W-1){1'b0}}, 1'b1} << r_delta_exp;
    assign lag_x     = LCMP_W'(r_lag);
    assign age_x     = $signed(LCMP_W'(r_age_limit));
    assign too_ahead = (r_delta_exp < DEXP_W'(CNT_W)) && (r_ahead > thr);
    assign too_old   = lag_x >= age_x;

    always_comb begin
        if (too_ahead) begin
            status = ST_AHEAD;
        end else if (too_old) begin
            status = ST_OLD;
        end else if (r_not_newer) begin
            status = ST_REPLAY;
        end else begin
            status = ST_ACCEPT;
        end
    end

    assign accept = (status == ST_ACCEPT);

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [SQN_W-1:0]    r_highest;
    logic                accept_go;
    logic [CNT_W-1:0]    hi_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (decide_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (decide_go) begin
            r_status  <= status;
            r_highest <= (accept && r_rcv_top) ? r_rcv : r_best_sqn;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.highest_sqn = r_highest;

    assign o_flags.no_in     = !i_in.valid;
    assign o_flags.m_big     = m_big;
    assign o_flags.r_big     = r_big;
    assign o_flags.scan_busy = scan_issue || r_scan_pend;
    assign o_flags.out_busy  = out_busy;

    assign accept_go = decide_go && accept;
    assign hi_cnt    = r_highest[SQN_W-1:IND_BITS];

    `SQN_ASSERT(a_idx_reduced, (i_uw.op == OP_SCAN) |-> (!m_big && !r_big), "index not reduced")
    `SQN_ASSERT(a_accept_top, accept_go |=> (hi_cnt >= rcv_cnt), "highest below accepted")
    `SQN_ASSERT(a_accept_vld, accept_go |=> r_vld[r_ridx[IDX_W-1:0]], "accepted entry not marked")
    `SQN_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !r_out_valid, "result valid after reset")
endmodule

`default_nettype wire

// ===== sim/sqn_freshness_check_test.sv =====
// ----------------------------------------------------------------------------
// sqn_freshness_check_test
// self-checking bench for the sequence number freshness check
// ----------------------------------------------------------------------------
// A queue of request beats feeds a clocked driver. A clocked monitor keeps its
// own copy of the sequence number table and the two registers, works out the
// status and highest stored number for every accepted request, and compares
// each result beat with the oldest outstanding verdict. A short directed set
// runs on reset defaults, then random phases sweep the register settings,
// extremes included. Both sides idle at random, and the result side holds off
// twice for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module sqn_freshness_check_test;
    import sqn_pkg::*;

    localparam int IND_W   = 5;
    localparam int ENTRIES = 32;
    localparam int CNT_W   = SQN_W - IND_W;

    localparam logic [SQN_W-1:0] SQN_ONES = {SQN_W{1'b1}};
    localparam logic [AGE_W-1:0] AGE_MAX  = {AGE_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MID      = 43'h1000_0000;

    typedef struct packed {
        logic [SQN_W-1:0] sqn;
        logic [SQN_W-1:0] msq;
        logic             msq_vld;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [SQN_W-1:0] highest;
    } t_verdict;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [AGE_W-1:0]     i_cfg_data;

    sqn_in_if  in_if ();
    sqn_out_if res_if ();

    sqn_freshness_check #(
        .IND_BITS      (IND_W),
        .TABLE_ENTRIES (ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_res      (res_if)
    );

    always #1 i_clk = ~i_clk;

    // bench copy of the block state
    logic [SQN_W-1:0]  sqn_store [ENTRIES];
    logic [DEXP_W-1:0] dexp_q = DEXP_RST;
    logic [AGE_W-1:0]  age_q  = AGE_RST;

    t_req             req_backlog [$];
    t_verdict         pending_verdicts [$];
    logic [SQN_W-1:0] sent_hist [$];
    logic [CNT_W-1:0] gen_base;

    int unsigned n_sent    = 0;
    int unsigned n_results = 0;
    int unsigned n_errors  = 0;

    logic        in_beat  = 1'b0;
    logic        res_beat = 1'b0;
    int unsigned req_gap  = 0;
    int unsigned tx_run   = 0;
    int unsigned rx_wait  = 0;
    int unsigned rx_run   = 0;
    int unsigned rx_hold  = 0;
    int unsigned rx_beats = 0;

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= 100) $display("%0t: %s", $time, what);
    endtask

    function automatic int unsigned top_slot();
        int unsigned best;
        logic [CNT_W-1:0] best_cnt;
        best = 0;
        best_cnt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sqn_store[i][SQN_W-1:IND_W] > best_cnt) begin
                best = i;
                best_cnt = sqn_store[i][SQN_W-1:IND_W];
            end
        end
        return best;
    endfunction

    function automatic t_verdict judge_sqn(input t_req req);
        t_verdict v;
        longint rcv_cnt, top_cnt, kept_cnt, ahead, lag, age_s;
        int unsigned slot;
        slot = req.sqn[IND_W-1:0];
        if (req.msq_vld) sqn_store[req.msq[IND_W-1:0]] = req.msq;
        rcv_cnt = req.sqn[SQN_W-1:IND_W];
        top_cnt = sqn_store[top_slot()][SQN_W-1:IND_W];
        kept_cnt = sqn_store[slot][SQN_W-1:IND_W];
        age_s = age_q;
        ahead = rcv_cnt - top_cnt;
        lag = top_cnt - rcv_cnt;
        if (dexp_q < 62 && ahead > (longint'(1) << dexp_q)) begin
            v.status = ST_AHEAD;
        end else if (lag >= age_s) begin
            v.status = ST_OLD;
        end else if (rcv_cnt <= kept_cnt) begin
            v.status = ST_REPLAY;
        end else begin
            v.status = ST_ACCEPT;
            sqn_store[slot] = req.sqn;
        end
        v.highest = sqn_store[top_slot()];
        return v;
    endfunction

    function automatic int unsigned draw_wait(inout int unsigned run);
        if (run != 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) run = $urandom_range(10, 40);
        return $urandom_range(0, 10);
    endfunction

    function automatic logic [SQN_W-1:0] rnd48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[SQN_W-1:0];
    endfunction

    function automatic logic [SQN_W-1:0] sqn_of(input logic [CNT_W-1:0] cnt,
                                                 input int unsigned idx);
        logic [31:0] i32;
        i32 = idx;
        return {cnt, i32[IND_W-1:0]};
    endfunction

    task automatic push_req(input logic [SQN_W-1:0] sqn, input logic [SQN_W-1:0] msq,
                            input logic msq_vld);
        req_backlog.push_back('{sqn: sqn, msq: msq, msq_vld: msq_vld});
        n_sent++;
    endtask

    task automatic wait_drained();
        while (n_results != n_sent) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [AGE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DELTA_EXP) dexp_q = val[DEXP_W-1:0];
        else age_q = val;
    endtask

    task automatic add_random_req();
        logic [CNT_W-1:0] cnt;
        logic [SQN_W-1:0] rcv, msq;
        logic             mv;
        int unsigned      kind;
        bit               fresh;
        kind = $urandom_range(0, 99);
        fresh = 1'b0;
        rcv = '0;
        cnt = gen_base;
        if (kind < 55) begin
            fresh = 1'b1;
        end else if (kind < 70) begin
            if (sent_hist.size() != 0) rcv = sent_hist[$urandom_range(0, sent_hist.size() - 1)];
            else fresh = 1'b1;
        end else if (kind < 80) begin
            if (age_q < AGE_W'(gen_base))
                cnt = gen_base - age_q[CNT_W-1:0] - 1 + $urandom_range(0, 2);
            else if (gen_base >= 4)
                cnt = gen_base - $urandom_range(0, 3);
            else
                fresh = 1'b1;
            rcv = sqn_of(cnt, $urandom_range(0, ENTRIES - 1));
        end else if (kind < 90) begin
            if (dexp_q <= 41) begin
                cnt = gen_base + (CNT_W'(1) << dexp_q) - 1 + $urandom_range(0, 2);
                rcv = sqn_of(cnt, $urandom_range(0, ENTRIES - 1));
            end else begin
                fresh = 1'b1;
            end
        end else begin
            if (dexp_q < 40) rcv = rnd48();
            else fresh = 1'b1;
        end
        if (fresh) begin
            cnt = gen_base + $urandom_range(1, 3);
            if ($urandom_range(0, 1) == 1) gen_base = cnt;
            rcv = sqn_of(cnt, $urandom_range(0, ENTRIES - 1));
            sent_hist.push_back(rcv);
            if (sent_hist.size() > 16) void'(sent_hist.pop_front());
        end
        mv = ($urandom_range(0, 4) == 0);
        if (mv) begin
            if ($urandom_range(0, 2) == 0)
                msq = {gen_base + $urandom_range(0, 3), rcv[IND_W-1:0]};
            else
                msq = sqn_of(gen_base + $urandom_range(0, 3), $urandom_range(0, ENTRIES - 1));
        end else begin
            msq = rnd48();
        end
        push_req(rcv, msq, mv);
    endtask

    task automatic run_phase(input logic [DEXP_W-1:0] dexp, input logic [AGE_W-1:0] age,
                             input int unsigned n);
        write_reg(CFG_DELTA_EXP, AGE_W'(dexp));
        write_reg(CFG_AGE_LIMIT, age);
        gen_base = sqn_store[top_slot()][SQN_W-1:IND_W];
        repeat (n) add_random_req();
        wait_drained();
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_req req;
        logic offer;
        offer = in_if.valid;
        if (in_beat) begin
            offer = 1'b0;
            req_gap = draw_wait(tx_run);
        end
        if (i_rst_n && !offer) begin
            if (req_gap != 0) begin
                req_gap--;
            end else if (req_backlog.size() != 0) begin
                req = req_backlog.pop_front();
                in_if.sqn_received  <= req.sqn;
                in_if.max_sqn       <= req.msq;
                in_if.max_sqn_valid <= req.msq_vld;
                offer = 1'b1;
            end
        end
        in_if.valid <= offer;
    end

    // result side ready, with two long hold-offs
    always @(negedge i_clk) begin
        if (res_beat) begin
            rx_beats++;
            rx_wait = draw_wait(rx_run);
            if (rx_beats == 150 || rx_beats == 720) rx_hold = 400;
        end else if (rx_hold != 0) begin
            rx_hold--;
        end else if (rx_wait != 0) begin
            rx_wait--;
        end
        res_if.ready <= i_rst_n && rx_hold == 0 && rx_wait == 0;
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_verdict want;
        in_beat  <= i_rst_n && in_if.valid && in_if.ready;
        res_beat <= i_rst_n && res_if.valid && res_if.ready;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready) begin
            n_results++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = pending_verdicts.pop_front();
                if (res_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              res_if.status, want.status));
                if (res_if.highest_sqn !== want.highest)
                    report_mismatch($sformatf("highest_sqn %h, want %h",
                                              res_if.highest_sqn, want.highest));
            end
        end
        if (i_rst_n && in_if.valid && in_if.ready === 1'b1) begin
            pending_verdicts.push_back(judge_sqn('{sqn: in_if.sqn_received,
                                                   msq: in_if.max_sqn,
                                                   msq_vld: in_if.max_sqn_valid}));
        end
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) sqn_store[i] = '0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_DELTA_EXP;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.sqn_received  = '0;
        in_if.max_sqn       = '0;
        in_if.max_sqn_valid = 1'b0;
        res_if.ready        = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats on reset defaults
        push_req(sqn_of(0, 0), SQN_ONES, 1'b0);
        push_req(sqn_of(1, 0), '0, 1'b0);
        push_req(sqn_of(1, 0), '0, 1'b0);
        push_req(sqn_of(1, 31), '0, 1'b0);
        push_req(sqn_of(MID + 2, 5), '0, 1'b0);
        push_req(sqn_of(MID + 1, 5), '0, 1'b0);
        push_req(SQN_ONES, '0, 1'b0);
        push_req(sqn_of(MID + 1 - 32, 6), '0, 1'b0);
        push_req(sqn_of(MID + 1 - 31, 6), '0, 1'b0);
        push_req('0, '0, 1'b0);
        push_req(sqn_of(MID + 10, 9), sqn_of(MID + 9, 9), 1'b1);
        push_req(sqn_of(MID + 9, 12), sqn_of(MID + 9, 12), 1'b1);
        push_req(sqn_of(MID + 11, 12), sqn_of(MID + 40, 3), 1'b1);
        push_req(sqn_of(MID + 40, 20), sqn_of(MID + 5, 3), 1'b1);
        push_req(sqn_of(MID + 40, 21), '0, 1'b0);
        push_req(sqn_of(MID + 39, 20), '0, 1'b0);
        push_req(sqn_of(MID + 41, 20), sqn_of(MID + 70, 31), 1'b1);
        push_req(sqn_of(MID + 41, 31), '0, 1'b0);
        wait_drained();

        run_phase(6'd0, 43'd32, 114);
        run_phase(6'd3, 43'd8, 114);
        run_phase(6'd28, 43'd0, 114);
        run_phase(6'd10, 43'd1000, 114);
        run_phase(6'd20, 43'd1, 114);
        run_phase(6'd42, AGE_MAX, 114);
        run_phase(6'd61, 43'd32, 114);
        run_phase(6'd62, 43'd100, 110);
        run_phase(6'd63, AGE_MAX, 100);

        // counters at the top of the range
        push_req(SQN_ONES, SQN_ONES, 1'b1);
        push_req(sqn_of(CNT_MAX, 0), '0, 1'b0);
        push_req('0, '0, 1'b0);
        push_req(sqn_of(1, 7), '0, 1'b0);
        push_req(sqn_of(CNT_MAX - 1, 3), sqn_of(0, 31), 1'b1);
        push_req(sqn_of(CNT_MAX, 3), '0, 1'b0);
        wait_drained();

        repeat (40) @(negedge i_clk);
        if (n_errors == 0 && pending_verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
